// ===== hw/rtl/mma_pkg.sv =====
`default_nettype none

package mma_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [6:0] data7_t;
  typedef logic [1:0] len_t;

  // Status codes and masks
  localparam byte_t STATUS_NOTE_OFF   = 8'h80;
  localparam byte_t STATUS_NOTE_ON    = 8'h90;
  localparam byte_t STATUS_POLY_PRESS = 8'hA0;
  localparam byte_t STATUS_CHAN_PRESS = 8'hD0;
  localparam byte_t STATUS_SYSEX      = 8'hF0;
  localparam byte_t STATUS_SYSEX_END  = 8'hF7;
  localparam byte_t STATUS_REALTIME   = 8'hF8;
  localparam byte_t STATUS_CH2_LIMIT  = 8'hC0;
  localparam byte_t STATUS_CH1_LIMIT  = 8'hE0;
  localparam byte_t STATUS_HI_MASK    = 8'hF0;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_CUT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLE = 1'd1;

  // Volume scaling: x / 100 == (x * 5243) >> 19 for x below 43690
  localparam data7_t PCT_FULL    = 7'd100;
  localparam int unsigned PROD_W  = 14;
  localparam int unsigned RECIP_W = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  // Data bytes expected by system status bytes 0xF0..0xFF
  localparam len_t SYS_LEN [16] = '{2'd1, 2'd1, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0,
                                    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};

  function automatic len_t length_of(input byte_t st);
    len_t len;
    if (st < STATUS_CH2_LIMIT) begin
      len = 2'd2;
    end else if (st < STATUS_CH1_LIMIT) begin
      len = 2'd1;
    end else if (st < STATUS_SYSEX) begin
      len = 2'd2;
    end else begin
      len = SYS_LEN[st[3:0]];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mma_sysex_store.sv =====
`default_nettype none

module mma_sysex_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire mma_pkg::byte_t wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output mma_pkg::byte_t     rd_data
);
  import mma_pkg::*;

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  // Single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mma_scale.sv =====
`default_nettype none

module mma_scale (
  input  wire logic            clk,
  input  wire mma_pkg::data7_t level,
  input  wire mma_pkg::data7_t volume_cut,
  output mma_pkg::data7_t      scaled
);
  import mma_pkg::*;

  data7_t                   factor;
  logic [PROD_W-1:0]        prod_r;
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  data7_t                   scaled_r;

  // Remaining percent; a cut of 100 or more leaves nothing
  assign factor = (volume_cut >= PCT_FULL) ? 7'd0 : (PCT_FULL - volume_cut);

  // Stage 1: level times remaining percent
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(level) * PROD_W'(factor);
  end

  // Stage 2: divide by 100 through the reciprocal
  assign recip_prod = (PROD_W+RECIP_W)'(prod_r) * (PROD_W+RECIP_W)'(RECIP_100);

  always_ff @(posedge clk) begin
    scaled_r <= recip_prod[RECIP_SHIFT+6:RECIP_SHIFT];
  end

  assign scaled = scaled_r;

endmodule

`default_nettype wire

// ===== hw/rtl/midi_message_assembler_unit.sv =====
// MIDI message assembler with running status.
// Input channel (in_valid/in_ready/in_midi_byte): one raw MIDI byte per beat.
// Output channel (out_valid/out_ready): one byte of a rebuilt message per beat,
// out_end_of_message marks the last byte of each message.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is the
// volume cut in percent, index 1 the output enable. Always ready; write only
// while the block is idle.
// One byte is handled at a time: in_ready is high only while idle. A byte that
// only updates state goes from decode straight back to idle. A finished channel
// message passes S_SCALE and S_SCALE2 and then sends up to 3 bytes. A sysex
// flush reads the store through its single read port at one byte a cycle while
// the receiver does not stall, then the trailing status byte is decoded again
// unless it is 0xF7.
// A stalled receiver holds the output register and the block waits; the next
// input byte is taken once the current one has produced all its beats.
// Reset (synchronous, rst_n low) clears the parser, sets cut 0, enable 1.
// With output disabled the parser still runs but no beats are presented.
`default_nettype none

module midi_message_assembler_unit #(
  parameter int unsigned SYSEX_DEPTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_midi_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_send_byte,
  output logic                               out_end_of_message,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [6:0]                    cfg_data
);
  import mma_pkg::*;

  localparam int unsigned AW = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SYSEX_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_FLUSH_START, S_FLUSH, S_FLUSH_END, S_SCALE, S_SCALE2, S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  byte_t         byte_r, byte_nxt;
  byte_t         running_status_r, running_status_nxt;
  len_t          exp_len_r, exp_len_nxt;
  len_t          data_pos_r, data_pos_nxt;
  data7_t        first_r, first_nxt;
  data7_t        second_r, second_nxt;
  logic          in_sysex_r, in_sysex_nxt;
  logic          status_unknown_r, status_unknown_nxt;
  logic [CW-1:0] sysex_count_r, sysex_count_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  len_t          emit_pos_r, emit_pos_nxt;
  logic          out_valid_r, out_valid_nxt;
  byte_t         out_byte_r, out_byte_nxt;
  logic          out_eom_r, out_eom_nxt;
  data7_t        volume_cut_r, volume_cut_nxt;
  logic          output_enable_r, output_enable_nxt;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  byte_t         mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  byte_t         mem_rd_data;

  byte_t         rs_hi;
  logic          scale_d1, scale_d2;
  data7_t        scale_in, scaled;
  byte_t         d1_out, d2_out;
  logic          slot_free;

  mma_sysex_store #(
    .DEPTH (SYSEX_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Velocity / pressure selection for the scaler
  assign rs_hi    = running_status_r & STATUS_HI_MASK;
  assign scale_d1 = (rs_hi == STATUS_CHAN_PRESS);
  assign scale_d2 = (rs_hi == STATUS_NOTE_OFF) || (rs_hi == STATUS_NOTE_ON) ||
                    (rs_hi == STATUS_POLY_PRESS);
  assign scale_in = scale_d1 ? first_r : second_r;

  mma_scale u_scale (
    .clk        (clk),
    .level      (scale_in),
    .volume_cut (volume_cut_r),
    .scaled     (scaled)
  );

  assign d1_out = {1'b0, ((exp_len_r != 2'd0) && (volume_cut_r != 7'd0) && scale_d1)
                         ? scaled : first_r};
  assign d2_out = {1'b0, ((exp_len_r == 2'd2) && (volume_cut_r != 7'd0) && scale_d2)
                         ? scaled : second_r};

  assign slot_free = !out_valid_r || out_ready;

  assign in_ready           = (state_r == S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_send_byte      = out_byte_r;
  assign out_end_of_message = out_eom_r;

  // Parser sequencer
  always_comb begin
    len_t len_new;
    len_t dp_inc;

    state_nxt          = state_r;
    byte_nxt           = byte_r;
    running_status_nxt = running_status_r;
    exp_len_nxt        = exp_len_r;
    data_pos_nxt       = data_pos_r;
    first_nxt          = first_r;
    second_nxt         = second_r;
    in_sysex_nxt       = in_sysex_r;
    status_unknown_nxt = status_unknown_r;
    sysex_count_nxt    = sysex_count_r;
    rd_idx_nxt         = rd_idx_r;
    emit_pos_nxt       = emit_pos_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_byte_nxt       = out_byte_r;
    out_eom_nxt        = out_eom_r;
    volume_cut_nxt     = volume_cut_r;
    output_enable_nxt  = output_enable_r;
    mem_wr_en          = 1'b0;
    mem_wr_addr        = sysex_count_r[AW-1:0];
    mem_wr_data        = byte_r;
    mem_rd_en          = 1'b0;
    mem_rd_addr        = '0;
    len_new            = length_of(byte_r);
    dp_inc             = data_pos_r + 2'd1;

    // Config writes
    if (cfg_valid) begin
      case (cfg_index)
        CFG_VOLUME_CUT:    volume_cut_nxt    = cfg_data;
        CFG_OUTPUT_ENABLE: output_enable_nxt = cfg_data[0];
        default:           ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt  = in_midi_byte;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        if (byte_r[7]) begin
          if ((byte_r < STATUS_REALTIME) && in_sysex_r) begin
            state_nxt = S_FLUSH_START;
          end else begin
            running_status_nxt = byte_r;
            exp_len_nxt        = len_new;
            data_pos_nxt       = 2'd0;
            status_unknown_nxt = 1'b0;
            if (byte_r == STATUS_SYSEX) begin
              in_sysex_nxt    = 1'b1;
              mem_wr_en       = 1'b1;
              mem_wr_addr     = '0;
              sysex_count_nxt = CW'(1);
              state_nxt       = S_IDLE;
            end else if (len_new == 2'd0) begin
              emit_pos_nxt = 2'd0;
              state_nxt    = S_EMIT;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end else if (in_sysex_r) begin
          // Store sysex data, drop beyond depth
          if (sysex_count_r < CW'(SYSEX_DEPTH)) begin
            mem_wr_en       = 1'b1;
            sysex_count_nxt = sysex_count_r + CW'(1);
          end
          state_nxt = S_IDLE;
        end else if (status_unknown_r) begin
          state_nxt = S_IDLE;
        end else begin
          if (dp_inc == 2'd1) begin
            first_nxt = byte_r[6:0];
          end else begin
            second_nxt = byte_r[6:0];
          end
          if (dp_inc >= exp_len_r) begin
            data_pos_nxt = 2'd0;
            emit_pos_nxt = 2'd0;
            state_nxt    = S_SCALE;
          end else begin
            data_pos_nxt = dp_inc;
            state_nxt    = S_IDLE;
          end
        end
      end

      S_FLUSH_START: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = '0;
        rd_idx_nxt  = '0;
        state_nxt   = S_FLUSH;
      end

      // One stored byte per beat; next read issued as the current one leaves
      S_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt = output_enable_r;
          out_byte_nxt  = mem_rd_data;
          out_eom_nxt   = 1'b0;
          if ((rd_idx_r + CW'(1)) < sysex_count_r) begin
            rd_idx_nxt  = rd_idx_r + CW'(1);
            mem_rd_en   = 1'b1;
            mem_rd_addr = rd_idx_nxt[AW-1:0];
          end else begin
            state_nxt = S_FLUSH_END;
          end
        end
      end

      S_FLUSH_END: begin
        if (slot_free) begin
          out_valid_nxt      = output_enable_r;
          out_byte_nxt       = STATUS_SYSEX_END;
          out_eom_nxt        = 1'b1;
          sysex_count_nxt    = '0;
          in_sysex_nxt       = 1'b0;
          status_unknown_nxt = 1'b1;
          state_nxt          = (byte_r == STATUS_SYSEX_END) ? S_IDLE : S_DECODE;
        end
      end

      S_SCALE:  state_nxt = S_SCALE2;
      S_SCALE2: state_nxt = S_EMIT;

      // Status, then up to two data bytes
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = output_enable_r;
          out_eom_nxt   = (emit_pos_r == exp_len_r);
          case (emit_pos_r)
            2'd0:    out_byte_nxt = running_status_r;
            2'd1:    out_byte_nxt = d1_out;
            default: out_byte_nxt = d2_out;
          endcase
          if (emit_pos_r == exp_len_r) begin
            state_nxt = S_IDLE;
          end else begin
            emit_pos_nxt = emit_pos_r + 2'd1;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      byte_r           <= '0;
      running_status_r <= '0;
      exp_len_r        <= '0;
      data_pos_r       <= '0;
      first_r          <= '0;
      second_r         <= '0;
      in_sysex_r       <= 1'b0;
      status_unknown_r <= 1'b0;
      sysex_count_r    <= '0;
      rd_idx_r         <= '0;
      emit_pos_r       <= '0;
      out_valid_r      <= 1'b0;
      out_byte_r       <= '0;
      out_eom_r        <= 1'b0;
      volume_cut_r     <= '0;
      output_enable_r  <= 1'b1;
    end else begin
      state_r          <= state_nxt;
      byte_r           <= byte_nxt;
      running_status_r <= running_status_nxt;
      exp_len_r        <= exp_len_nxt;
      data_pos_r       <= data_pos_nxt;
      first_r          <= first_nxt;
      second_r         <= second_nxt;
      in_sysex_r       <= in_sysex_nxt;
      status_unknown_r <= status_unknown_nxt;
      sysex_count_r    <= sysex_count_nxt;
      rd_idx_r         <= rd_idx_nxt;
      emit_pos_r       <= emit_pos_nxt;
      out_valid_r      <= out_valid_nxt;
      out_byte_r       <= out_byte_nxt;
      out_eom_r        <= out_eom_nxt;
      volume_cut_r     <= volume_cut_nxt;
      output_enable_r  <= output_enable_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sysex_count_r <= CW'(SYSEX_DEPTH))
    else $error("sysex count beyond store depth");

  a_sysex_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    in_sysex_r |-> (sysex_count_r != '0))
    else $error("sysex active with empty store");

  a_beat_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> output_enable_r)
    else $error("beat presented while output disabled");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted byte not decoded");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (data_pos_r != 2'd3) && ((state_r != S_EMIT) || (emit_pos_r <= exp_len_r)))
    else $error("data or emit position out of range");
`endif

endmodule

`default_nettype wire
